// ===== hdl/lmwq_pkg.sv =====
// Shared constants for the lock manager with wait queue.
// Holds parameter defaults and result status codes; no dependencies.
package lmwq_pkg;

    localparam int LOCK_COUNT_DEF      = 64;
    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int REQUESTER_COUNT_DEF = 256;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

endpackage

// ===== hdl/lmwq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the lock flags and the wait queue; no dependencies.
module lmwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lock_manager_with_wait_queue.sv =====
// Top level of the central lock manager with a FIFO wait queue.
// Depends on lmwq_pkg and instantiates lmwq_ram for lock flags and queue entries.
//
// Usage:
// Requests arrive on the s_ channel: s_tuser is the opcode (0 acquire, 1 release),
// s_tdata carries the requester and the lock number. Every request produces exactly
// one result transaction on the m_ channel with the grant flag, the granted requester
// and lock, a status code and the number of queued requests after the step.
// A request for lock 0 or past the last lock goes from idle straight to the output
// state. An acquire, or a release of a free lock or while the queue is empty, passes
// through the lock read, check and output states. A release of a held lock with
// requests queued reads the queue one entry per cycle through its single read port
// until it finds the oldest waiter for that lock. That waiter is granted, and any
// entries behind it are moved down; when nobody waits for the lock, the lock is freed.
// The block handles one request at a time; s_tready is high only while it is idle,
// which begins as the result register is loaded.
// A finished result waits in the output register while the next request is taken,
// and a stalled receiver holds the block only when a second result is ready.
// After reset the lock flag memory is swept clear, one lock per cycle, so s_tready
// stays low until every lock is cleared; the wait queue starts empty.
module lock_manager_with_wait_queue #(
    parameter int LOCK_COUNT      = lmwq_pkg::LOCK_COUNT_DEF,
    parameter int QUEUE_DEPTH     = lmwq_pkg::QUEUE_DEPTH_DEF,
    parameter int REQUESTER_COUNT = lmwq_pkg::REQUESTER_COUNT_DEF,
    localparam int REQ_W    = $clog2(REQUESTER_COUNT),
    localparam int LOCK_W   = $clog2(LOCK_COUNT),
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1),
    localparam int S_DATA_W = ((REQ_W + LOCK_W + 7) / 8) * 8,
    localparam int M_DATA_W = ((1 + REQ_W + LOCK_W + lmwq_pkg::STATUS_W + CNT_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // requester, lock_id
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // granted, grant_requester, grant_lock, status, pending_count
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = REQ_W + LOCK_W;

    localparam logic [LOCK_W:0]   LOCK_LIMIT = (LOCK_W + 1)'(LOCK_COUNT);
    localparam logic [LOCK_W-1:0] LOCK_LAST  = LOCK_W'(LOCK_COUNT - 1);
    localparam logic [CNT_W-1:0]  Q_FULL     = CNT_W'(QUEUE_DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LRD   = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SHIFT = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic                          op_reg, op_next;
    logic [REQ_W-1:0]              req_reg, req_next;
    logic [LOCK_W-1:0]             lk_reg, lk_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [LOCK_W-1:0]             clr_reg, clr_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [IDX_W-1:0]              pidx_reg, pidx_next;
    logic                          pv_reg, pv_next;
    logic [CNT_W-1:0]              src_reg, src_next;
    logic [IDX_W-1:0]              sprev_reg, sprev_next;
    logic                          sv_reg, sv_next;
    logic                          res_granted_reg, res_granted_next;
    logic [REQ_W-1:0]              res_req_reg, res_req_next;
    logic [lmwq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]           m_tdata_reg, m_tdata_next;

    logic                lock_we;
    logic [LOCK_W-1:0]   lock_waddr;
    logic                lock_wdata;
    logic                lock_rdata;
    logic                q_we;
    logic [IDX_W-1:0]    q_waddr;
    logic [ENTRY_W-1:0]  q_wdata;
    logic [IDX_W-1:0]    q_raddr;
    logic [ENTRY_W-1:0]  q_rdata;
    logic [LOCK_W-1:0]   q_lock;
    logic [REQ_W-1:0]    q_req;
    logic [LOCK_W-1:0]   s_lock;
    logic [LOCK_W-1:0]   grant_lock;

    lmwq_ram #(
        .WIDTH (1),
        .DEPTH (LOCK_COUNT)
    ) u_lock_ram (
        .aclk  (aclk),
        .we    (lock_we),
        .waddr (lock_waddr),
        .wdata (lock_wdata),
        .raddr (lk_reg),
        .rdata (lock_rdata)
    );

    lmwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign q_lock     = q_rdata[REQ_W +: LOCK_W];
    assign q_req      = q_rdata[REQ_W-1:0];
    assign s_lock     = s_tdata[REQ_W +: LOCK_W];
    assign grant_lock = res_granted_reg ? lk_reg : '0;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        req_next         = req_reg;
        lk_next          = lk_reg;
        count_next       = count_reg;
        clr_next         = clr_reg;
        idx_next         = idx_reg;
        pidx_next        = pidx_reg;
        pv_next          = pv_reg;
        src_next         = src_reg;
        sprev_next       = sprev_reg;
        sv_next          = sv_reg;
        res_granted_next = res_granted_reg;
        res_req_next     = res_req_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        lock_we          = 1'b0;
        lock_waddr       = lk_reg;
        lock_wdata       = 1'b0;
        q_we             = 1'b0;
        q_waddr          = '0;
        q_wdata          = q_rdata;
        q_raddr          = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                lock_we    = 1'b1;
                lock_waddr = clr_reg;
                lock_wdata = 1'b0;
                if (clr_reg == LOCK_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next          = s_tuser;
                    req_next         = s_tdata[REQ_W-1:0];
                    lk_next          = s_lock;
                    res_granted_next = 1'b0;
                    res_req_next     = '0;
                    res_status_next  = lmwq_pkg::STATUS_OK;
                    if (s_lock == '0 || {1'b0, s_lock} >= LOCK_LIMIT) begin
                        res_status_next = lmwq_pkg::STATUS_INVALID;
                        state_next      = ST_OUT;
                    end else begin
                        state_next = ST_LRD;
                    end
                end
            end
            ST_LRD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                state_next = ST_OUT;
                if (op_reg == lmwq_pkg::OP_ACQUIRE) begin
                    if (!lock_rdata) begin
                        lock_we          = 1'b1;
                        lock_wdata       = 1'b1;
                        res_granted_next = 1'b1;
                        res_req_next     = req_reg;
                    end else if (count_reg == Q_FULL) begin
                        res_status_next = lmwq_pkg::STATUS_FULL;
                    end else begin
                        q_we       = 1'b1;
                        q_waddr    = count_reg[IDX_W-1:0];
                        q_wdata    = {lk_reg, req_reg};
                        count_next = count_reg + 1'b1;
                    end
                end else begin
                    if (!lock_rdata) begin
                        res_status_next = lmwq_pkg::STATUS_INVALID;
                    end else if (count_reg == '0) begin
                        lock_we    = 1'b1;
                        lock_wdata = 1'b0;
                    end else begin
                        idx_next   = '0;
                        pv_next    = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pv_reg && q_lock == lk_reg) begin
                    res_granted_next = 1'b1;
                    res_req_next     = q_req;
                    src_next         = CNT_W'(pidx_reg) + 1'b1;
                    sv_next          = 1'b0;
                    state_next       = ST_SHIFT;
                end else if (pv_reg && (CNT_W'(pidx_reg) + 1'b1) == count_reg) begin
                    lock_we    = 1'b1;
                    lock_wdata = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    q_raddr   = idx_reg;
                    pidx_next = idx_reg;
                    pv_next   = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_SHIFT: begin
                if (sv_reg) begin
                    q_we    = 1'b1;
                    q_waddr = sprev_reg - 1'b1;
                    q_wdata = q_rdata;
                end
                if (src_reg < count_reg) begin
                    q_raddr    = src_reg[IDX_W-1:0];
                    sprev_next = src_reg[IDX_W-1:0];
                    sv_next    = 1'b1;
                    src_next   = src_reg + 1'b1;
                end else if (!sv_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_OUT;
                end else begin
                    sv_next = 1'b0;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({count_reg, res_status_reg, grant_lock,
                                               res_req_reg, res_granted_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            pv_reg       <= 1'b0;
            sv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            pv_reg       <= pv_next;
            sv_reg       <= sv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        req_reg         <= req_next;
        lk_reg          <= lk_next;
        idx_reg         <= idx_next;
        pidx_reg        <= pidx_next;
        src_reg         <= src_next;
        sprev_reg       <= sprev_next;
        res_granted_reg <= res_granted_next;
        res_req_reg     <= res_req_next;
        res_status_reg  <= res_status_next;
        m_tdata_reg     <= m_tdata_next;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for lock_manager_with_wait_queue: directed table, then random traffic.
// Predicts replies from its own lock table and wait list or a typed row; checks them in order.
// Depends on lmwq_pkg and the lock_manager_with_wait_queue RTL.
module testbench;

    localparam int REQ_W       = 8;
    localparam int LOCK_W      = 6;
    localparam int CNT_W       = 5;
    localparam int S_W         = 16;
    localparam int M_W         = 24;
    localparam int WAIT_SLOTS  = lmwq_pkg::QUEUE_DEPTH_DEF;
    localparam int RANDOM_REQS = 950;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              granted;
        logic [REQ_W-1:0]  grant_requester;
        logic [LOCK_W-1:0] grant_lock;
        logic [1:0]        status;
        logic [CNT_W-1:0]  pending_count;
    } lm_reply_t;

    typedef struct {
        logic              op;
        logic [REQ_W-1:0]  requester;
        logic [LOCK_W-1:0] lock_id;
        bit                typed;
        lm_reply_t         reply;
    } stim_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    bit [63:0]         lock_busy = '0;
    logic [REQ_W-1:0]  waiter_req[$];
    logic [LOCK_W-1:0] waiter_lock[$];
    lm_reply_t         owed_replies[$];
    stim_row_t         directed_rows[$];

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned replies_seen = 0;
    int unsigned grant_count = 0;
    int unsigned full_count = 0;
    int unsigned invalid_count = 0;
    int unsigned deepest_wait = 0;
    bit          send_eager = 1'b0;
    bit          recv_eager = 1'b0;

    lock_manager_with_wait_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d replies outstanding.",
                     cycle_count, owed_replies.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic lm_reply_t predict_reply(logic op, logic [REQ_W-1:0] req,
                                                logic [LOCK_W-1:0] lk);
        lm_reply_t r;
        int        i;
        r = '0;
        r.status = lmwq_pkg::STATUS_OK;
        if (lk == 0) begin
            r.status = lmwq_pkg::STATUS_INVALID;
        end else if (op == lmwq_pkg::OP_ACQUIRE) begin
            if (!lock_busy[lk]) begin
                lock_busy[lk] = 1'b1;
                r.granted = 1'b1;
                r.grant_requester = req;
                r.grant_lock = lk;
            end else if (waiter_lock.size() >= WAIT_SLOTS) begin
                r.status = lmwq_pkg::STATUS_FULL;
            end else begin
                waiter_req = {waiter_req, req};
                waiter_lock = {waiter_lock, lk};
            end
        end else if (!lock_busy[lk]) begin
            r.status = lmwq_pkg::STATUS_INVALID;
        end else begin
            lock_busy[lk] = 1'b0;
            for (i = 0; i < waiter_lock.size(); i++) begin
                if (waiter_lock[i] == lk) begin
                    lock_busy[lk] = 1'b1;
                    r.granted = 1'b1;
                    r.grant_requester = waiter_req[i];
                    r.grant_lock = lk;
                    waiter_req.delete(i);
                    waiter_lock.delete(i);
                    break;
                end
            end
        end
        r.pending_count = CNT_W'(waiter_lock.size());
        return r;
    endfunction

    function automatic void add_row(logic op, int req, int lk, bit typed, bit g = 0,
                                    int greq = 0, int glk = 0,
                                    logic [1:0] st = lmwq_pkg::STATUS_OK, int pend = 0);
        stim_row_t row;
        row.op = op;
        row.requester = REQ_W'(req);
        row.lock_id = LOCK_W'(lk);
        row.typed = typed;
        row.reply.granted = g;
        row.reply.grant_requester = REQ_W'(greq);
        row.reply.grant_lock = LOCK_W'(glk);
        row.reply.status = st;
        row.reply.pending_count = CNT_W'(pend);
        directed_rows = {directed_rows, row};
    endfunction

    task automatic send_request(logic op, logic [REQ_W-1:0] req, logic [LOCK_W-1:0] lk,
                                bit typed, lm_reply_t typed_reply);
        int        gap;
        lm_reply_t r;
        if ($urandom_range(0, 31) == 0)
            send_eager = ~send_eager;
        gap = send_eager ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, lk, req};
        do @(posedge aclk); while (!s_tready);
        r = predict_reply(op, req, lk);
        owed_replies = {owed_replies, (typed ? typed_reply : r)};
        if (r.granted)
            grant_count++;
        if (r.status == lmwq_pkg::STATUS_FULL)
            full_count++;
        if (r.status == lmwq_pkg::STATUS_INVALID)
            invalid_count++;
        if (r.pending_count > deepest_wait)
            deepest_wait = r.pending_count;
    endtask

    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0)
                recv_eager = ~recv_eager;
            stall = recv_eager ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        lm_reply_t want;
        lm_reply_t got;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            got.granted         = m_tdata[0];
            got.grant_requester = m_tdata[8:1];
            got.grant_lock      = m_tdata[14:9];
            got.status          = m_tdata[16:15];
            got.pending_count   = m_tdata[21:17];
            if (owed_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Reply %0d arrived with nothing expected: %h", replies_seen,
                             m_tdata);
            end else begin
                want = owed_replies.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Reply %0d differs: expected g=%0d req=%0d lock=%0d ",
                                  "st=%0d pend=%0d, got g=%0d req=%0d lock=%0d st=%0d ",
                                  "pend=%0d"}, replies_seen,
                                 want.granted, want.grant_requester, want.grant_lock,
                                 want.status, want.pending_count,
                                 got.granted, got.grant_requester, got.grant_lock,
                                 got.status, got.pending_count);
                end
            end
        end
    end

    initial begin
        int          i;
        int          n;
        int          pool_base;
        int          pool_size;
        int          acq_pct;
        int          start;
        logic        op;
        logic [5:0]  lk;
        logic [7:0]  req;
        lm_reply_t   none;

        none = '0;
        add_row(lmwq_pkg::OP_ACQUIRE, 0, 0, 1, 0, 0, 0, lmwq_pkg::STATUS_INVALID, 0);
        add_row(lmwq_pkg::OP_RELEASE, 255, 0, 1, 0, 0, 0, lmwq_pkg::STATUS_INVALID, 0);
        add_row(lmwq_pkg::OP_RELEASE, 170, 63, 1, 0, 0, 0, lmwq_pkg::STATUS_INVALID, 0);
        add_row(lmwq_pkg::OP_ACQUIRE, 255, 63, 1, 1, 255, 63, lmwq_pkg::STATUS_OK, 0);
        add_row(lmwq_pkg::OP_ACQUIRE, 0, 1, 1, 1, 0, 1, lmwq_pkg::STATUS_OK, 0);
        add_row(lmwq_pkg::OP_ACQUIRE, 255, 63, 1, 0, 0, 0, lmwq_pkg::STATUS_OK, 1);
        for (i = 0; i < 15; i++)
            add_row(lmwq_pkg::OP_ACQUIRE, (i * 17) ^ 8'h5a, (i % 2 == 0) ? 1 : 63, 0);
        add_row(lmwq_pkg::OP_ACQUIRE, 85, 1, 1, 0, 0, 0, lmwq_pkg::STATUS_FULL, 16);
        add_row(lmwq_pkg::OP_RELEASE, 0, 63, 0);
        add_row(lmwq_pkg::OP_RELEASE, 0, 1, 0);
        add_row(lmwq_pkg::OP_ACQUIRE, 170, 42, 0);
        add_row(lmwq_pkg::OP_RELEASE, 85, 42, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].requester,
                         directed_rows[k].lock_id, directed_rows[k].typed,
                         directed_rows[k].reply);

        // Traffic concentrates on a small group of locks so the wait list fills,
        // drains and compacts; a minority of requests are arbitrary.
        pool_base = 1;
        pool_size = 1;
        acq_pct = 50;
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n % 60 == 0) begin
                pool_size = $urandom_range(1, 4);
                pool_base = $urandom_range(1, 64 - pool_size);
                acq_pct = $urandom_range(25, 90);
            end
            req = REQ_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 15) begin
                op = 1'($urandom_range(0, 1));
                lk = LOCK_W'($urandom_range(0, 63));
            end else begin
                op = lmwq_pkg::OP_ACQUIRE;
                lk = LOCK_W'(pool_base + $urandom_range(0, pool_size - 1));
                if ($urandom_range(0, 99) >= acq_pct) begin
                    if (waiter_lock.size() > 0 && $urandom_range(0, 1) == 1) begin
                        op = lmwq_pkg::OP_RELEASE;
                        lk = waiter_lock[$urandom_range(0, waiter_lock.size() - 1)];
                    end else begin
                        start = $urandom_range(0, pool_size - 1);
                        for (i = 0; i < pool_size; i++) begin
                            if (op == lmwq_pkg::OP_ACQUIRE &&
                                lock_busy[pool_base + (start + i) % pool_size]) begin
                                op = lmwq_pkg::OP_RELEASE;
                                lk = LOCK_W'(pool_base + (start + i) % pool_size);
                            end
                        end
                    end
                end
            end
            send_request(op, req, lk, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (owed_replies.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Checked %0d replies: %0d grants, %0d queue-full rejections, %0d errors.",
                 replies_seen, grant_count, full_count, invalid_count);
        $display("Deepest wait list seen: %0d of %0d entries.", deepest_wait, WAIT_SLOTS);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatching replies.", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
